[hdl/ktrk_pkg.sv]
// ktrk_pkg: shared constants, types and helpers for the top-k stream tracker
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps
`default_nettype none

package ktrk_pkg;

  // built depth of the cell chain
  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int KCFG_W = 7;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_K_USED = 1'b0;

  // data and flags handed from one cell to the next
  typedef struct packed {
    logic signed [VAL_W-1:0] val;  // stored value
    logic                    vld;  // stored entry is held
    logic                    eff;  // entry counts for this beat
    logic                    gt;   // incoming key lands at or above this cell
  } link_t;

  // control broadcast to every cell
  typedef struct packed {
    logic signed [VAL_W-1:0] key;
    logic                    restart;
    logic [CNT_W-1:0]        k;
    logic                    upd;
  } cell_ctl_t;

  // clamp the programmed k to 1..DEPTH
  function automatic logic [CNT_W-1:0] k_eff(input logic [KCFG_W-1:0] k);
    int unsigned kk;
    kk = int'(k);
    if (kk == 0) kk = 1;
    if (kk > DEPTH) kk = DEPTH;
    return CNT_W'(kk);
  endfunction

endpackage

`default_nettype wire

[hdl/ktrk_if.sv]
// ktrk_in_if / ktrk_out_if: valid/ready channels for input and result beats
// depends on ktrk_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ktrk_in_if;
  import ktrk_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    restart;
  logic                    preload_last;
  modport source (output valid, value, restart, preload_last, input ready);
  modport sink (input valid, value, restart, preload_last, output ready);
endinterface

interface ktrk_out_if;
  import ktrk_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] kth_value;
  logic                    full_res;
  modport source (output valid, kth_value, full_res, input ready);
  modport sink (input valid, kth_value, full_res, output ready);
endinterface

`default_nettype wire

[hdl/ktrk_cfg.sv]
// ktrk_cfg: apb-style register file holding k_used
// depends on ktrk_pkg
`timescale 1ns / 1ps
`default_nettype none

module ktrk_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ktrk_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [ktrk_pkg::PDATA_W-1:0]  pwdata,
  output logic      [ktrk_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output logic      [ktrk_pkg::KCFG_W-1:0]   k_used
);
  import ktrk_pkg::*;

  logic              sel_k;
  logic [KCFG_W-1:0] k_used_r;
  logic [KCFG_W-1:0] k_used_nxt;

  // word decode, byte lanes ignored
  assign sel_k  = (paddr[PADDR_W-1] == REG_K_USED);
  assign pready = 1'b1;

  // register write on the access phase
  always_comb begin
    k_used_nxt = k_used_r;
    if (psel && penable && pwrite && sel_k) begin
      k_used_nxt = pwdata[KCFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_used_r <= KCFG_W'(1);
    end else begin
      k_used_r <= k_used_nxt;
    end
  end

  // read back
  assign prdata = sel_k ? {{(PDATA_W-KCFG_W){1'b0}}, k_used_r} : '0;
  assign k_used = k_used_r;

endmodule

`default_nettype wire

[hdl/ktrk_cell.sv]
// ktrk_cell: one slot of the descending sorted chain
// depends on ktrk_pkg; takes the upper neighbor's link and drives its own
`timescale 1ns / 1ps
`default_nettype none

module ktrk_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [ktrk_pkg::IDX_W-1:0]  idx,
  input  wire ktrk_pkg::cell_ctl_t         ctl,
  input  wire ktrk_pkg::link_t             prev,
  output ktrk_pkg::link_t                  link
);
  import ktrk_pkg::*;

  logic                    in_k;
  logic                    eff;
  logic                    gt;
  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;
  logic                    vld_r;
  logic                    vld_nxt;

  // slot is inside the tracked window; entries past k are cut off
  assign in_k = CNT_W'(idx) < ctl.k;
  assign eff  = vld_r && !ctl.restart && in_k;
  // ties stay below the existing entry
  assign gt   = !eff || (ctl.key > val_r);

  // shift down from the neighbor, take the key, or keep
  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    if (ctl.upd) begin
      if (gt) begin
        val_nxt = prev.gt ? prev.val : ctl.key;
      end
      vld_nxt = in_k && (eff || prev.eff);
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign link.val = val_r;
  assign link.vld = vld_r;
  assign link.eff = eff;
  assign link.gt  = gt;

endmodule

`default_nettype wire

[hdl/ktrk_pick.sv]
// ktrk_pick: finds the tail of the held run and the full flag
// depends on ktrk_pkg; reads the stored links of all cells
`timescale 1ns / 1ps
`default_nettype none

module ktrk_pick (
  input  wire ktrk_pkg::link_t                 taps [ktrk_pkg::DEPTH],
  input  wire logic [ktrk_pkg::CNT_W-1:0]      k,
  output logic signed [ktrk_pkg::VAL_W-1:0]    kth_value,
  output logic                                 full_res,
  output logic [ktrk_pkg::DEPTH-1:0]           vld_vec
);
  import ktrk_pkg::*;

  logic [DEPTH-1:0] vld_hi;
  logic [DEPTH-1:0] last;
  logic [DEPTH-1:0] at_k;

  // gather valid bits; the next-lower neighbor's bit marks the tail
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      vld_vec[i] = taps[i].vld;
    end
  end

  assign vld_hi = vld_vec >> 1;
  assign last   = vld_vec & ~vld_hi;

  // one-hot and-or select of the smallest held value
  always_comb begin
    kth_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      at_k[i] = (CNT_W'(i) == (k - CNT_W'(1)));
      kth_value = kth_value | (last[i] ? taps[i].val : '0);
    end
  end

  assign full_res = |(vld_vec & at_k);

endmodule

`default_nettype wire

[hdl/kth_largest_stream_tracker.sv]
// kth_largest_stream_tracker: top level, chain of DEPTH sorted cells with apb config
// flow: a beat is captured, inserted across the cell chain, then its tail select is
//   loaded into the output register, which waits while the output is stalled; no new
//   input beat is taken until that result is loaded
// reset: held set empty, k_used = 1, no result pending
// depends on ktrk_pkg, ktrk_if, ktrk_cfg, ktrk_cell, ktrk_pick
`timescale 1ns / 1ps
`default_nettype none

module kth_largest_stream_tracker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ktrk_in_if.sink                            in_bus,
  ktrk_out_if.source                         out_bus,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ktrk_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [ktrk_pkg::PDATA_W-1:0]  pwdata,
  output logic      [ktrk_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import ktrk_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INS  = 3'b010,
    S_RES  = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic signed [VAL_W-1:0] key_r, key_nxt;
  logic                    restart_r, restart_nxt;
  logic                    out_vld_r, out_vld_nxt;
  logic signed [VAL_W-1:0] out_val_r, out_val_nxt;
  logic                    out_full_r, out_full_nxt;

  logic [KCFG_W-1:0]       k_used;
  logic [CNT_W-1:0]        k;
  cell_ctl_t               ctl;
  link_t                   chain [DEPTH+1];
  link_t                   taps [DEPTH];
  logic signed [VAL_W-1:0] pick_val;
  logic                    pick_full;
  logic [DEPTH-1:0]        vld_vec;
  logic                    in_acc;
  logic                    out_load;

  // configuration
  ktrk_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .k_used  (k_used)
  );

  assign k = k_eff(k_used);

  // handshakes
  assign in_bus.ready = (state_r == S_IDLE);
  assign in_acc       = in_bus.valid && in_bus.ready;
  assign out_load     = (state_r == S_RES) && (!out_vld_r || out_bus.ready);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    key_nxt     = key_r;
    restart_nxt = restart_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          key_nxt     = in_bus.value;
          restart_nxt = in_bus.restart;
          state_nxt   = S_INS;
        end
      end
      S_INS: begin
        state_nxt = S_RES;
      end
      S_RES: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // broadcast to the chain
  assign ctl.key     = key_r;
  assign ctl.restart = restart_r;
  assign ctl.k       = k;
  assign ctl.upd     = (state_r == S_INS);

  // head of the chain: nothing shifts in from above; held count grows by one, capped at k, or restarts at one
  assign chain[0].val = '0;
  assign chain[0].vld = 1'b1;
  assign chain[0].eff = 1'b1;
  assign chain[0].gt  = 1'b0;

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ktrk_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (IDX_W'(g)),
      .ctl   (ctl),
      .prev  (chain[g]),
      .link  (chain[g+1])
    );
    assign taps[g] = chain[g+1];
  end

  // tail select
  ktrk_pick u_pick (
    .taps      (taps),
    .k         (k),
    .kth_value (pick_val),
    .full_res  (pick_full),
    .vld_vec   (vld_vec)
  );

  // output register
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_val_nxt  = out_val_r;
    out_full_nxt = out_full_r;
    if (out_load) begin
      out_vld_nxt  = 1'b1;
      out_val_nxt  = pick_val;
      out_full_nxt = pick_full;
    end else if (out_bus.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    restart_r  <= restart_nxt;
    out_val_r  <= out_val_nxt;
    out_full_r <= out_full_nxt;
  end

  assign out_bus.valid     = out_vld_r;
  assign out_bus.kth_value = out_val_r;
  assign out_bus.full_res  = out_full_r;

  // held entries always form one run from the top of the chain
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_vec >> 1) & ~vld_vec) == '0)
    else $error("held entries not contiguous");

  // an accepted beat goes through insert then result
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_INS) ##1 (state_r == S_RES))
    else $error("item did not step through insert and result");

  // after an insert the held count never exceeds k
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES) |-> ($countones(vld_vec) <= int'(k)))
    else $error("held count above k");

  // a delivered result always comes from a nonempty set
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> vld_vec[0])
    else $error("result from empty set");

endmodule

`default_nettype wire
